// File: rtl/core/bnd_pkg.sv
package bnd_pkg;

  typedef enum logic [3:0] {
    FK_STATUS     = 4'd0,
    FK_CELL_VOLT  = 4'd1,
    FK_AVG_VOLT   = 4'd2,
    FK_DELTA_VOLT = 4'd3,
    FK_CELL_RES   = 4'd4,
    FK_PACK_VOLT  = 4'd5,
    FK_PACK_POWER = 4'd6,
    FK_CYCLES     = 4'd7,
    FK_CYCLE_AH   = 4'd8,
    FK_CHARGE     = 4'd9,
    FK_DISCHARGE  = 4'd10
  } field_kind_e;

  typedef enum logic [1:0] {
    PK_UNKNOWN = 2'd0,
    PK_INFO    = 2'd1,
    PK_CELL    = 2'd2
  } packet_kind_e;

  typedef struct packed {
    field_kind_e  field_kind;
    logic [4:0]   cell_index;
    logic [31:0]  field_value;
    packet_kind_e packet_kind;
    logic [1:0]   chunk_after;
  } result_t;

  localparam logic [7:0] HDR_INFO_TAG = 8'h03;
  localparam logic [7:0] HDR_CELL_TAG = 8'h02;

  localparam logic [8:0] MIN_NOTIFY = 9'd20;
  localparam logic [8:0] POS_MAX    = 9'd511;
  localparam logic [8:0] TAG_POS    = 9'd4;
  localparam logic [8:0] PREFIX_END = 9'd3;

  // chunk 1 offsets (last byte of each field)
  localparam logic [8:0] CELL_V_FIRST = 9'd7;
  localparam logic [8:0] AVG_LAST     = 9'd59;
  localparam logic [8:0] DELTA_LAST   = 9'd61;
  localparam logic [8:0] CELL_R_FIRST = 9'd65;
  localparam logic [8:0] PACK_V_LAST  = 9'd121;
  localparam logic [8:0] POWER_LAST   = 9'd125;
  // chunk 3 offsets
  localparam logic [8:0] CYCLES_EMIT  = 9'd4;
  localparam logic [8:0] CYC_AH_LAST  = 9'd7;
  localparam logic [8:0] CHARGE_LAST  = 9'd40;
  localparam logic [8:0] DISCH_LAST   = 9'd42;

  localparam logic [1:0] CHUNK_INFO = 2'd0;
  localparam logic [1:0] CHUNK_CELL = 2'd1;
  localparam logic [1:0] CHUNK_TAIL = 2'd3;

  function automatic logic [7:0] hdr_prefix(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h55;
      2'd1:    b = 8'hAA;
      2'd2:    b = 8'hEB;
      default: b = 8'h90;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/bnd_if.sv
interface bnd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [8:0] notify_length;
  logic       first_byte;

  modport source (output valid, data_byte, notify_length, first_byte, input ready);
  modport sink   (input valid, data_byte, notify_length, first_byte, output ready);
endinterface

interface bnd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_kind;
  logic [4:0]  cell_index;
  logic [31:0] field_value;
  logic [1:0]  packet_kind;
  logic [1:0]  chunk_after;

  modport source (output valid, field_kind, cell_index, field_value, packet_kind,
                  chunk_after, input ready);
  modport sink   (input valid, field_kind, cell_index, field_value, packet_kind,
                  chunk_after, output ready);
endinterface

// File: rtl/core/bnd_core.sv
module bnd_core #(
  parameter int CELL_SLOTS       = 23,
  parameter int FULL_FRAME_BYTES = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        data_byte_i,
  input  logic [8:0]        notify_length_i,
  input  logic              first_byte_i,
  output logic              res_valid_o,
  output bnd_pkg::result_t  res_o
);

  localparam logic [8:0] CellVLast = 9'(5 + 2 * CELL_SLOTS);
  localparam logic [8:0] CellRLast = 9'(63 + 2 * CELL_SLOTS);
  localparam logic [8:0] FullLen   = 9'(FULL_FRAME_BYTES);

  logic [1:0]  chunk_q, chunk_d;
  bnd_pkg::packet_kind_e kind_q, kind_d;
  logic [8:0]  pos_q, pos_d;
  logic [8:0]  len_q, len_d;
  logic [1:0]  flags_q, flags_d;
  logic [31:0] asm_q, asm_d;
  logic [31:0] cyc_q, cyc_d;

  logic [8:0]  p;
  logic        active;
  logic        full;
  logic [15:0] lo16;
  logic [8:0]  cv_off;
  logic [8:0]  cr_off;

  always_comb begin
    p       = first_byte_i ? 9'd0 : pos_q;
    chunk_d = chunk_q;
    kind_d  = kind_q;
    pos_d   = pos_q;
    len_d   = len_q;
    flags_d = flags_q;
    asm_d   = asm_q;
    cyc_d   = cyc_q;
    res_valid_o = 1'b0;
    res_o       = '{field_kind: bnd_pkg::FK_STATUS, cell_index: 5'd0, field_value: 32'd0,
                    packet_kind: bnd_pkg::PK_UNKNOWN, chunk_after: 2'd0};
    lo16   = 16'd0;
    cv_off = p - bnd_pkg::CELL_V_FIRST;
    cr_off = p - bnd_pkg::CELL_R_FIRST;
    active = 1'b0;
    full   = 1'b0;

    if (en_i) begin
      if (first_byte_i) begin
        len_d   = notify_length_i;
        flags_d = 2'b11;
      end
      pos_d  = (p != bnd_pkg::POS_MAX) ? p + 9'd1 : p;
      active = (p < len_d) && (len_d >= bnd_pkg::MIN_NOTIFY);

      if (active) begin
        asm_d = {data_byte_i, asm_q[31:8]};
        lo16  = asm_d[31:16];

        if (p < bnd_pkg::TAG_POS) begin
          if (data_byte_i != bnd_pkg::hdr_prefix(p[1:0])) flags_d = 2'b00;
        end else if (p == bnd_pkg::TAG_POS) begin
          if (data_byte_i != bnd_pkg::HDR_INFO_TAG) flags_d[0] = 1'b0;
          if (data_byte_i != bnd_pkg::HDR_CELL_TAG) flags_d[1] = 1'b0;
        end
        if (p == bnd_pkg::PREFIX_END) cyc_d = asm_d;

        if (p == bnd_pkg::TAG_POS) begin
          priority if (flags_d[0]) begin
            kind_d  = bnd_pkg::PK_INFO;
            chunk_d = bnd_pkg::CHUNK_INFO;
          end else if (flags_d[1]) begin
            kind_d  = bnd_pkg::PK_CELL;
            chunk_d = bnd_pkg::CHUNK_CELL;
          end else begin
            kind_d = (chunk_q != 2'd0) ? bnd_pkg::PK_CELL : bnd_pkg::PK_UNKNOWN;
          end
        end

        full = (len_d == FullLen) && (p >= bnd_pkg::TAG_POS) &&
               (kind_d == bnd_pkg::PK_CELL);

        if (p == len_d - 9'd1) begin
          if (kind_d == bnd_pkg::PK_CELL) chunk_d = chunk_d + 2'd1;
          res_valid_o       = 1'b1;
          res_o.packet_kind = kind_d;
          res_o.chunk_after = chunk_d;
        end else if (full && chunk_d == bnd_pkg::CHUNK_CELL) begin
          priority if (p[0] && p >= bnd_pkg::CELL_V_FIRST && p <= CellVLast) begin
            res_valid_o       = 1'b1;
            res_o.field_kind  = bnd_pkg::FK_CELL_VOLT;
            res_o.cell_index  = cv_off[5:1];
            res_o.field_value = {16'd0, lo16};
          end else if (p == bnd_pkg::AVG_LAST) begin
            res_valid_o       = 1'b1;
            res_o.field_kind  = bnd_pkg::FK_AVG_VOLT;
            res_o.field_value = {16'd0, lo16};
          end else if (p == bnd_pkg::DELTA_LAST) begin
            res_valid_o       = 1'b1;
            res_o.field_kind  = bnd_pkg::FK_DELTA_VOLT;
            res_o.field_value = {16'd0, lo16};
          end else if (p[0] && p >= bnd_pkg::CELL_R_FIRST && p <= CellRLast) begin
            res_valid_o       = 1'b1;
            res_o.field_kind  = bnd_pkg::FK_CELL_RES;
            res_o.cell_index  = cr_off[5:1];
            res_o.field_value = {16'd0, lo16};
          end else if (p == bnd_pkg::PACK_V_LAST) begin
            res_valid_o       = 1'b1;
            res_o.field_kind  = bnd_pkg::FK_PACK_VOLT;
            res_o.field_value = asm_d;
          end else if (p == bnd_pkg::POWER_LAST) begin
            res_valid_o       = 1'b1;
            res_o.field_kind  = bnd_pkg::FK_PACK_POWER;
            res_o.field_value = asm_d;
          end else begin
            res_valid_o = 1'b0;
          end
        end else if (full && chunk_d == bnd_pkg::CHUNK_TAIL) begin
          priority if (p == bnd_pkg::CYCLES_EMIT) begin
            res_valid_o       = 1'b1;
            res_o.field_kind  = bnd_pkg::FK_CYCLES;
            res_o.field_value = cyc_q;
          end else if (p == bnd_pkg::CYC_AH_LAST) begin
            res_valid_o       = 1'b1;
            res_o.field_kind  = bnd_pkg::FK_CYCLE_AH;
            res_o.field_value = asm_d;
          end else if (p == bnd_pkg::CHARGE_LAST) begin
            res_valid_o       = 1'b1;
            res_o.field_kind  = bnd_pkg::FK_CHARGE;
            res_o.field_value = {16'd0, lo16};
          end else if (p == bnd_pkg::DISCH_LAST) begin
            res_valid_o       = 1'b1;
            res_o.field_kind  = bnd_pkg::FK_DISCHARGE;
            res_o.field_value = {16'd0, lo16};
          end else begin
            res_valid_o = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= 2'd0;
      kind_q  <= bnd_pkg::PK_UNKNOWN;
      pos_q   <= 9'd0;
      len_q   <= 9'd0;
      flags_q <= 2'b11;
      asm_q   <= 32'd0;
      cyc_q   <= 32'd0;
    end else begin
      chunk_q <= chunk_d;
      kind_q  <= kind_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      flags_q <= flags_d;
      asm_q   <= asm_d;
      cyc_q   <= cyc_d;
    end
  end

endmodule

// File: rtl/core/bms_notification_decoder.sv
// Result words are registered: output slot first, skid slot if the output slot is held.
// One input byte per cycle while the skid slot is empty; at most one result word per byte.
// A two-word output buffer lets input flow while one result word waits downstream.
// Reset (rst_ni, async, active low) clears the decoder state and empties the output buffer.
module bms_notification_decoder #(
  parameter int CELL_SLOTS       = 23,
  parameter int FULL_FRAME_BYTES = 128
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  bnd_in_if.sink    in_i,
  bnd_out_if.source out_o
);

  logic             accept;
  logic             res_valid;
  bnd_pkg::result_t res;

  logic             out_valid_q;
  bnd_pkg::result_t out_q;
  logic             skid_valid_q;
  bnd_pkg::result_t skid_q;
  logic             pop;
  logic             push;

  assign in_i.ready = !skid_valid_q;
  assign accept     = in_i.valid && in_i.ready;
  assign pop        = out_valid_q && out_o.ready;
  assign push       = accept && res_valid;

  bnd_core #(
    .CELL_SLOTS      (CELL_SLOTS),
    .FULL_FRAME_BYTES(FULL_FRAME_BYTES)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (accept),
    .data_byte_i    (in_i.data_byte),
    .notify_length_i(in_i.notify_length),
    .first_byte_i   (in_i.first_byte),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.field_kind  = out_q.field_kind;
  assign out_o.cell_index  = out_q.cell_index;
  assign out_o.field_value = out_q.field_value;
  assign out_o.packet_kind = out_q.packet_kind;
  assign out_o.chunk_after = out_q.chunk_after;

endmodule
